/* sv/tks_pkg.sv */
// shared types and constants of the top-k sorted insertion block
`default_nettype none
package tks_pkg;

   localparam int LIST_DEPTH_DEFAULT = 16;
   localparam int NUM_LISTS_DEFAULT  = 4;

   localparam logic [4:0] MAX_ENTRIES_RESET = 5'd16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic REG_MAX_ENTRIES = 1'b0;

   typedef struct packed {
      logic              op;
      logic [1:0]        list_select;
      logic signed [31:0] value;
      logic [3:0]        read_index;
   } req_type;

   typedef struct packed {
      logic              placed;
      logic [3:0]        position;
      logic              read_valid;
      logic signed [31:0] read_value;
      logic [4:0]        entry_count;
   } rsp_type;

   typedef struct packed {
      logic cmp;
      logic upd;
   } cell_ctl_type;

endpackage
`default_nettype wire

/* sv/tks_cell.sv */
// one rank position of every list: compare against the new value and shift down
`default_nettype none
module tks_cell #(
   parameter int INDEX     = 0,
   parameter int NUM_LISTS = tks_pkg::NUM_LISTS_DEFAULT,
   parameter int CNT_W     = 5,
   parameter int SEL_W     = 2
) (
   input  wire                      clock,
   input  tks_pkg::cell_ctl_type    ctl,
   input  wire [SEL_W-1:0]          sel_idx,
   input  wire signed [31:0]        value,
   input  wire [CNT_W-1:0]          cnt,
   input  wire [CNT_W-1:0]          lim,
   input  wire                      prev_ins,
   input  wire signed [31:0]        prev_rd,
   output logic                     ins,
   output logic                     head,
   output logic signed [31:0]       rd
);

   localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX);

   logic signed [31:0] val_ff [NUM_LISTS];
   logic               gt_ff;
   logic signed [31:0] rd_ff;
   logic               below_lim;

   always_ff @(posedge clock) begin
      if (ctl.cmp) begin
         gt_ff <= value > val_ff[sel_idx];
         rd_ff <= val_ff[sel_idx];
      end
      if (ctl.upd && ins && below_lim) begin
         // the first shifting cell takes the new value, the rest take their neighbour's
         val_ff[sel_idx] <= prev_ins ? prev_rd : value;
      end
   end

   always_comb begin
      below_lim = POS < lim;
      ins       = ((POS < cnt) && gt_ff) || (POS == cnt);
      head      = ins && !prev_ins && below_lim;
      rd        = rd_ff;
   end

endmodule
`default_nettype wire

/* sv/top_k_sorted_insert.sv */
// top level: item control, limit register, list counts and the row of rank cells
`default_nettype none
// Keeps NUM_LISTS descending ranked lists of signed 32-bit values, up to max_entries
// each (at least 1, at most LIST_DEPTH), in a row of LIST_DEPTH cells; cell k holds
// rank k of every list. Each item is accepted into the item register, then every cell
// compares the value with its entry of the addressed list in parallel, and in the
// update state the cells at and after the insertion point shift down by one while the
// result is written to the output register. The update state waits while an earlier
// result is still held in that register; a new item is accepted once the previous one
// has left the row. Cell entries are not cleared after reset: list counts start at
// zero and only entries below a count are ever used. Lowering max_entries leaves longer
// lists readable until their next insert, which first cuts them to the limit.
module top_k_sorted_insert #(
   parameter int LIST_DEPTH = tks_pkg::LIST_DEPTH_DEFAULT,
   parameter int NUM_LISTS  = tks_pkg::NUM_LISTS_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  tks_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output tks_pkg::rsp_type  rsp_data,
   input  wire               csr_psel,
   input  wire               csr_penable,
   input  wire               csr_pwrite,
   input  wire [2:0]         csr_paddr,
   input  wire [31:0]        csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int SEL_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;

   logic [1:0]             state_ff, state_in;
   tks_pkg::req_type       item_ff;
   tks_pkg::rsp_type       rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [4:0]             max_entries_ff;
   logic [CNT_W-1:0]       counts_ff [NUM_LISTS];

   logic                   csr_wr;
   logic                   out_free;
   logic                   upd_go;
   logic [SEL_W+1:0]       sel_wide;
   logic                   sel_ok;
   logic [SEL_W-1:0]       sel_idx;
   logic [CNT_W-1:0]       cnt_raw, cnt_ins, lim, new_cnt;
   logic [LIM_W-1:0]       me_wide, lim_wide;
   logic                   is_insert;
   logic                   placed;
   logic [IDX_W-1:0]       pos;
   logic [IDX_W+3:0]       pos_wide;
   logic [CNT_W+4:0]       cnt_out_wide;
   logic [IDX_W+3:0]       ridx_wide;
   logic                   rd_ok;
   logic signed [31:0]     rd_sel;
   tks_pkg::cell_ctl_type  ctl;

   logic                   ins_chain  [LIST_DEPTH];
   logic                   head_chain [LIST_DEPTH];
   logic signed [31:0]     rd_chain   [LIST_DEPTH];

   // configuration port
   always_comb begin
      csr_pready = 1'b1;
      csr_wr     = csr_psel && csr_penable && csr_pwrite;
      csr_prdata = (csr_paddr[2] == tks_pkg::REG_MAX_ENTRIES) ? {27'd0, max_entries_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= tks_pkg::MAX_ENTRIES_RESET;
      end else if (csr_wr && csr_paddr[2] == tks_pkg::REG_MAX_ENTRIES) begin
         max_entries_ff <= csr_pwdata[4:0];
      end
   end

   // addressed list and effective limit
   always_comb begin
      sel_wide  = {{SEL_W{1'b0}}, item_ff.list_select};
      sel_ok    = sel_wide < (SEL_W+2)'(NUM_LISTS);
      sel_idx   = sel_wide[SEL_W-1:0];
      cnt_raw   = sel_ok ? counts_ff[sel_idx] : '0;
      me_wide   = LIM_W'(max_entries_ff);
      if (me_wide == '0) begin
         lim_wide = LIM_W'(1);
      end else if (me_wide > LIM_W'(LIST_DEPTH)) begin
         lim_wide = LIM_W'(LIST_DEPTH);
      end else begin
         lim_wide = me_wide;
      end
      lim       = lim_wide[CNT_W-1:0];
      cnt_ins   = (cnt_raw > lim) ? lim : cnt_raw;
      is_insert = item_ff.op == tks_pkg::OP_INSERT;
   end

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      upd_go   = (state_ff == S_UPD) && out_free;
      ctl.cmp  = state_ff == S_CMP;
      ctl.upd  = upd_go && is_insert && sel_ok;
   end

   // row of rank cells
   for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
      logic               prev_ins;
      logic signed [31:0] prev_rd;
      if (k == 0) begin : g_first
         assign prev_ins = 1'b0;
         assign prev_rd  = 32'sd0;
      end else begin : g_next
         assign prev_ins = ins_chain[k-1];
         assign prev_rd  = rd_chain[k-1];
      end
      tks_cell #(
         .INDEX     (k),
         .NUM_LISTS (NUM_LISTS),
         .CNT_W     (CNT_W),
         .SEL_W     (SEL_W)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .sel_idx  (sel_idx),
         .value    (item_ff.value),
         .cnt      (cnt_ins),
         .lim      (lim),
         .prev_ins (prev_ins),
         .prev_rd  (prev_rd),
         .ins      (ins_chain[k]),
         .head     (head_chain[k]),
         .rd       (rd_chain[k])
      );
   end

   // insertion point and read selection
   always_comb begin
      placed = 1'b0;
      pos    = '0;
      rd_sel = 32'sd0;
      ridx_wide = {{IDX_W{1'b0}}, item_ff.read_index};
      for (int k = 0; k < LIST_DEPTH; k++) begin
         placed = placed | head_chain[k];
         if (head_chain[k]) begin
            pos = pos | IDX_W'(k);
         end
         if (ridx_wide == (IDX_W+4)'(k)) begin
            rd_sel = rd_chain[k];
         end
      end
      placed  = placed && is_insert && sel_ok;
      new_cnt = (placed && cnt_ins != lim) ? cnt_ins + CNT_W'(1) : cnt_ins;
      rd_ok   = sel_ok && ({{CNT_W{1'b0}}, item_ff.read_index} < {4'd0, cnt_raw});
      pos_wide = {4'd0, pos};
   end

   always_comb begin
      rsp_in = rsp_ff;
      cnt_out_wide = '0;
      if (upd_go) begin
         if (is_insert) begin
            cnt_out_wide       = {5'd0, new_cnt};
            rsp_in.placed      = placed;
            rsp_in.position    = placed ? pos_wide[3:0] : 4'd0;
            rsp_in.read_valid  = 1'b0;
            rsp_in.read_value  = 32'sd0;
         end else begin
            cnt_out_wide       = {5'd0, cnt_raw};
            rsp_in.placed      = 1'b0;
            rsp_in.position    = 4'd0;
            rsp_in.read_valid  = rd_ok;
            rsp_in.read_value  = rd_ok ? rd_sel : 32'sd0;
         end
         rsp_in.entry_count = cnt_out_wide[4:0];
      end
   end

   // item sequencing
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.upd) begin
            counts_ff[sel_idx] <= new_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      // no beat is taken while reset is held
      req_ready = (state_ff == S_IDLE) && !reset;
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

endmodule
`default_nettype wire
